### rtl/core/trle_pkg.sv
// Package for the TGA run-length stream decoder.
// Holds the result word type, phase codes and header constants.
// No dependencies.
`default_nettype none

package trle_pkg;

  // Decoder phases.
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_RAWIMG = 3'd1;
  localparam logic [2:0] PH_PKTHDR = 3'd2;
  localparam logic [2:0] PH_PKTPIX = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  // Header byte positions.
  localparam logic [4:0] HDR_TYPE     = 5'd2;
  localparam logic [4:0] HDR_WIDTH_LO = 5'd12;
  localparam logic [4:0] HDR_WIDTH_HI = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
  localparam logic [4:0] HDR_DEPTH    = 5'd16;
  localparam logic [4:0] HDR_LAST     = 5'd17;

  // Image type codes in the file.
  localparam logic [7:0] TYPE_TRUECOLOR     = 8'd2;
  localparam logic [7:0] TYPE_RLE_TRUECOLOR = 8'd10;

  // Supported depths.
  localparam logic [7:0] DEPTH_24 = 8'd24;
  localparam logic [7:0] DEPTH_32 = 8'd32;

  // Result kinds.
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  // Image kinds reported in the header result.
  localparam logic [1:0] IMG_RAW   = 2'd0;
  localparam logic [1:0] IMG_RLE   = 2'd1;
  localparam logic [1:0] IMG_UNSUP = 2'd2;

  // Channel counts.
  localparam logic [2:0] CH_RGB  = 3'd3;
  localparam logic [2:0] CH_RGBA = 3'd4;

  // RLE packet header split point.
  localparam logic [7:0] PKT_RUN_BASE = 8'd127;

  typedef struct packed {
    logic       kind;
    logic [15:0] width;
    logic [15:0] height;
    logic [2:0]  channels;
    logic [1:0]  image_kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  repeat_res;
    logic        last;
  } trle_result_t;

endpackage

`default_nettype wire

### rtl/core/trle_out_reg.sv
// Output register for the TGA run-length decoder result words.
// Depends on trle_pkg for the result word type.
`default_nettype none

module trle_out_reg (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        load,
  input  wire trle_pkg::trle_result_t load_data,
  output logic                       free,
  output logic                       valid,
  input  wire                        ready,
  output trle_pkg::trle_result_t     data
);
  import trle_pkg::*;

  // The slot can take a new word when empty or when the held word leaves now.
  assign free = !valid || ready;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  // Held result word.
  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

`default_nettype wire

### rtl/core/tga_rle_stream_decoder.sv
// Top level of the TGA run-length stream decoder.
// Depends on trle_pkg and trle_out_reg.
//
//   channel | handshake                    | word
//   byte    | byte_valid / byte_ready      | data_byte, start_of_file
//   result  | result_valid / result_ready  | kind .. last (header or pixel run)
//
// A result is in the output register on the cycle following its last byte.
// Sustained rate is one byte per cycle while result_ready is high; byte_ready
// drops only while a result waits in the output register and the consumer
// holds result_ready low. Synchronous reset clears the parser state and
// result_valid, and the first bytes parse as a header. No clearing pass needed.
`default_nettype none

module tga_rle_stream_decoder (
  input  wire         clk,
  input  wire         rst,
  input  wire         byte_valid,
  output logic        byte_ready,
  input  wire  [7:0]  data_byte,
  input  wire         start_of_file,
  output logic        result_valid,
  input  wire         result_ready,
  output logic        kind,
  output logic [15:0] width,
  output logic [15:0] height,
  output logic [2:0]  channels,
  output logic [1:0]  image_kind,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha,
  output logic [7:0]  repeat_res,
  output logic        last
);
  import trle_pkg::*;

  // Decoder state.
  logic [2:0]  phase, phase_next;
  logic [4:0]  header_index, header_index_next;
  logic [7:0]  image_type, image_type_next;
  logic [15:0] width_reg, width_reg_next;
  logic [15:0] height_reg, height_reg_next;
  logic [7:0]  depth_bits, depth_bits_next;
  logic [31:0] pixels_left, pixels_left_next;
  logic [7:0]  packet_left, packet_left_next;
  logic        run_packet, run_packet_next;
  logic [1:0]  byte_in_pixel, byte_in_pixel_next;
  logic [23:0] colour_buffer, colour_buffer_next;
  logic [31:0] area;

  // Values seen after a start-of-file restart.
  logic [2:0]  phase_cur;
  logic [4:0]  header_index_cur;
  logic [7:0]  image_type_cur;
  logic [15:0] width_cur;
  logic [15:0] height_cur;
  logic [7:0]  depth_cur;
  logic [31:0] pixels_left_cur;
  logic [7:0]  packet_left_cur;
  logic        run_cur;
  logic [1:0]  byte_in_pixel_cur;
  logic [23:0] colour_cur;

  logic         accept;
  logic         has_result;
  trle_result_t res;
  trle_result_t res_held;
  logic         slot_free;
  logic         depth_ok;
  logic [1:0]   img_kind;
  logic [1:0]   final_index;
  logic [7:0]   rep;
  logic [31:0]  rep_clip;
  logic [7:0]   pkt_dec;
  logic [7:0]   alpha_val;
  logic         in_packet;

  assign accept     = byte_valid && byte_ready;
  assign byte_ready = slot_free;

  // Pixel count is registered ahead of the last header byte.
  always_ff @(posedge clk) begin
    area <= {16'd0, width_reg} * {16'd0, height_reg};
  end

  // A start mark restarts parsing from a cleared state.
  always_comb begin
    phase_cur         = start_of_file ? PH_HEADER : phase;
    header_index_cur  = start_of_file ? 5'd0 : header_index;
    image_type_cur    = start_of_file ? 8'd0 : image_type;
    width_cur         = start_of_file ? 16'd0 : width_reg;
    height_cur        = start_of_file ? 16'd0 : height_reg;
    depth_cur         = start_of_file ? 8'd0 : depth_bits;
    pixels_left_cur   = start_of_file ? 32'd0 : pixels_left;
    packet_left_cur   = start_of_file ? 8'd0 : packet_left;
    run_cur           = start_of_file ? 1'b0 : run_packet;
    byte_in_pixel_cur = start_of_file ? 2'd0 : byte_in_pixel;
    colour_cur        = start_of_file ? 24'd0 : colour_buffer;
  end

  // Per-byte decode step.
  always_comb begin
    phase_next         = phase_cur;
    header_index_next  = header_index_cur;
    image_type_next    = image_type_cur;
    width_reg_next     = width_cur;
    height_reg_next    = height_cur;
    depth_bits_next    = depth_cur;
    pixels_left_next   = pixels_left_cur;
    packet_left_next   = packet_left_cur;
    run_packet_next    = run_cur;
    byte_in_pixel_next = byte_in_pixel_cur;
    colour_buffer_next = colour_cur;
    has_result         = 1'b0;
    res                = '0;

    depth_ok    = (depth_cur == DEPTH_24) || (depth_cur == DEPTH_32);
    if (image_type_cur == TYPE_TRUECOLOR && depth_ok) begin
      img_kind = IMG_RAW;
    end else if (image_type_cur == TYPE_RLE_TRUECOLOR && depth_ok) begin
      img_kind = IMG_RLE;
    end else begin
      img_kind = IMG_UNSUP;
    end
    final_index = (depth_cur == DEPTH_32) ? 2'd3 : 2'd2;
    in_packet   = (phase_cur == PH_PKTPIX);
    rep         = (in_packet && run_cur) ? packet_left_cur : 8'd1;
    rep_clip    = ({24'd0, rep} > pixels_left_cur) ? pixels_left_cur : {24'd0, rep};
    pkt_dec     = packet_left_cur - 8'd1;
    alpha_val   = 8'd0;

    case (phase_cur)
      PH_HEADER: begin
        case (header_index_cur)
          HDR_TYPE:      image_type_next = data_byte;
          HDR_WIDTH_LO:  width_reg_next = {width_cur[15:8], data_byte};
          HDR_WIDTH_HI:  width_reg_next = {data_byte, width_cur[7:0]};
          HDR_HEIGHT_LO: height_reg_next = {height_cur[15:8], data_byte};
          HDR_HEIGHT_HI: height_reg_next = {data_byte, height_cur[7:0]};
          HDR_DEPTH:     depth_bits_next = data_byte;
          default: ;
        endcase
        header_index_next = header_index_cur + 5'd1;
        if (header_index_cur == HDR_LAST) begin
          has_result         = 1'b1;
          pixels_left_next   = area;
          byte_in_pixel_next = 2'd0;
          packet_left_next   = 8'd0;
          run_packet_next    = 1'b0;
          colour_buffer_next = 24'd0;
          res.kind       = KIND_HEADER;
          res.width      = width_cur;
          res.height     = height_cur;
          res.channels   = (depth_cur > DEPTH_24) ? CH_RGBA : CH_RGB;
          res.image_kind = img_kind;
          if (img_kind == IMG_UNSUP || area == 32'd0) begin
            res.last   = 1'b1;
            phase_next = PH_DONE;
          end else if (img_kind == IMG_RAW) begin
            phase_next = PH_RAWIMG;
          end else begin
            phase_next = PH_PKTHDR;
          end
        end
      end

      PH_PKTHDR: begin
        if (data_byte < 8'd128) begin
          packet_left_next = data_byte + 8'd1;
          run_packet_next  = 1'b0;
        end else begin
          packet_left_next = data_byte - PKT_RUN_BASE;
          run_packet_next  = 1'b1;
        end
        byte_in_pixel_next = 2'd0;
        phase_next         = PH_PKTPIX;
      end

      PH_RAWIMG, PH_PKTPIX: begin
        // Stored order is blue, green, red, then optional alpha.
        case (byte_in_pixel_cur)
          2'd0:    colour_buffer_next = {colour_cur[23:8], data_byte};
          2'd1:    colour_buffer_next = {colour_cur[23:16], data_byte, colour_cur[7:0]};
          2'd2:    colour_buffer_next = {data_byte, colour_cur[15:0]};
          default: alpha_val = data_byte;
        endcase
        if (byte_in_pixel_cur < final_index) begin
          byte_in_pixel_next = byte_in_pixel_cur + 2'd1;
        end else begin
          byte_in_pixel_next = 2'd0;
          has_result         = 1'b1;
          pixels_left_next   = pixels_left_cur - rep_clip;
          if (in_packet && run_cur) begin
            packet_left_next = 8'd0;
          end else if (in_packet) begin
            packet_left_next = pkt_dec;
          end
          res.kind       = KIND_PIXEL;
          res.red        = colour_buffer_next[23:16];
          res.green      = colour_buffer_next[15:8];
          res.blue       = colour_buffer_next[7:0];
          res.alpha      = alpha_val;
          res.repeat_res = rep_clip[7:0];
          res.last       = (rep_clip == pixels_left_cur);
          if (rep_clip == pixels_left_cur) begin
            phase_next = PH_DONE;
          end else if (in_packet && (run_cur || pkt_dec == 8'd0)) begin
            phase_next = PH_PKTHDR;
          end
        end
      end

      default: ;
    endcase
  end

  // State registers, updated on each accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      header_index  <= 5'd0;
      image_type    <= 8'd0;
      width_reg     <= 16'd0;
      height_reg    <= 16'd0;
      depth_bits    <= 8'd0;
      pixels_left   <= 32'd0;
      packet_left   <= 8'd0;
      run_packet    <= 1'b0;
      byte_in_pixel <= 2'd0;
      colour_buffer <= 24'd0;
    end else if (accept) begin
      phase         <= phase_next;
      header_index  <= header_index_next;
      image_type    <= image_type_next;
      width_reg     <= width_reg_next;
      height_reg    <= height_reg_next;
      depth_bits    <= depth_bits_next;
      pixels_left   <= pixels_left_next;
      packet_left   <= packet_left_next;
      run_packet    <= run_packet_next;
      byte_in_pixel <= byte_in_pixel_next;
      colour_buffer <= colour_buffer_next;
    end
  end

  // Result register.
  trle_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && has_result),
    .load_data (res),
    .free      (slot_free),
    .valid     (result_valid),
    .ready     (result_ready),
    .data      (res_held)
  );

  assign kind       = res_held.kind;
  assign width      = res_held.width;
  assign height     = res_held.height;
  assign channels   = res_held.channels;
  assign image_kind = res_held.image_kind;
  assign red        = res_held.red;
  assign green      = res_held.green;
  assign blue       = res_held.blue;
  assign alpha      = res_held.alpha;
  assign repeat_res = res_held.repeat_res;
  assign last       = res_held.last;

endmodule

`default_nettype wire

### rtl/core/trle_chk.sv
// Port-level checker for the TGA run-length stream decoder, with its bind.
// Depends on trle_pkg and the tga_rle_stream_decoder port list.
`default_nettype none

module trle_chk (
  input wire        clk,
  input wire        rst,
  input wire        byte_valid,
  input wire        byte_ready,
  input wire        result_valid,
  input wire        result_ready,
  input wire        kind,
  input wire [15:0] width,
  input wire [15:0] height,
  input wire [2:0]  channels,
  input wire [1:0]  image_kind,
  input wire [7:0]  red,
  input wire [7:0]  green,
  input wire [7:0]  blue,
  input wire [7:0]  alpha,
  input wire [7:0]  repeat_res,
  input wire        last
);
  import trle_pkg::*;

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid &&
      $stable({kind, width, height, channels, image_kind, red, green, blue, alpha,
               repeat_res, last}))
    else $error("result word changed while stalled");

  // Input is held off only while a result waits on a stalled consumer.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !byte_ready |-> result_valid && !result_ready)
    else $error("byte_ready low without a stalled result");

  // Header words carry a legal channel count and image kind.
  a_header: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == KIND_HEADER |->
      (channels == CH_RGB || channels == CH_RGBA) &&
      (image_kind == IMG_RAW || image_kind == IMG_RLE || image_kind == IMG_UNSUP))
    else $error("bad header word");

  // An unsupported image finishes with its header word.
  a_unsup_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == KIND_HEADER && image_kind == IMG_UNSUP |-> last)
    else $error("unsupported header without last");

  // Pixel words carry a nonzero repeat and no header fields.
  a_pixel: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == KIND_PIXEL |->
      repeat_res != 8'd0 && width == 16'd0 && height == 16'd0 && channels == 3'd0)
    else $error("bad pixel word");

endmodule

bind tga_rle_stream_decoder trle_chk u_trle_chk (
  .clk          (clk),
  .rst          (rst),
  .byte_valid   (byte_valid),
  .byte_ready   (byte_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .kind         (kind),
  .width        (width),
  .height       (height),
  .channels     (channels),
  .image_kind   (image_kind),
  .red          (red),
  .green        (green),
  .blue         (blue),
  .alpha        (alpha),
  .repeat_res   (repeat_res),
  .last         (last)
);

`default_nettype wire

### verif/tb_tga_rle_stream_decoder.sv
// Self-checking bench for tga_rle_stream_decoder. It streams TGA files byte by byte
// and checks every header and pixel-run word against a decoder model kept in the bench.
// Depends on trle_pkg and the decoder RTL.

module tb_tga_rle_stream_decoder;
  import trle_pkg::*;

  localparam int ITEMS       = 1500;
  localparam int CALM_AFTER  = 1250;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 8;

  localparam logic [4:0] HDR_FULL = HDR_LAST + 5'd1;

  // File type and depth codes that the decoder must refuse.
  localparam logic [7:0] TYPE_NONE  = 8'd0;
  localparam logic [7:0] TYPE_GRAY  = 8'd3;
  localparam logic [7:0] TYPE_BOGUS = 8'hFF;
  localparam logic [7:0] DEPTH_NONE = 8'd0;
  localparam logic [7:0] DEPTH_16   = 8'd16;
  localparam logic [7:0] DEPTH_MAX  = 8'hFF;

  // One directed file: header fields, a short body and the header word when it is pinned.
  typedef struct packed {
    logic             sof;
    logic [4:0]       hdr_len;
    logic [7:0]       img_type;
    logic [15:0]      w;
    logic [15:0]      h;
    logic [7:0]       bpp;
    logic [4:0]       body_len;
    logic [127:0]     body;
    logic             pinned;
    trle_result_t     hdr_word;
  } file_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_ready;
  logic [7:0]  data_byte = 8'd0;
  logic        start_of_file = 1'b0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic        kind;
  logic [15:0] width;
  logic [15:0] height;
  logic [2:0]  channels;
  logic [1:0]  image_kind;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [7:0]  repeat_res;
  logic        last;

  // Decoder model state.
  logic [2:0]  dec_phase;
  logic [4:0]  dec_hdr_idx;
  logic [7:0]  dec_type;
  logic [15:0] dec_w;
  logic [15:0] dec_h;
  logic [7:0]  dec_bpp;
  logic [31:0] dec_px_left;
  logic [7:0]  dec_pkt_left;
  logic        dec_run;
  logic [1:0]  dec_pix_byte;
  logic [23:0] dec_bgr;

  trle_result_t awaited_words[$];
  trle_result_t oldest_word;
  file_row_t    dir_files[13];

  logic idle_on = 1'b1;
  int   stall_left = 0;
  int   errors = 0;
  int   cycles = 0;
  int   live_bytes = 0;
  int   files_sent = 0;
  int   header_words = 0;
  int   pixel_words = 0;
  int   run_words = 0;

  tga_rle_stream_decoder DUT (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .data_byte    (data_byte),
    .start_of_file(start_of_file),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .kind         (kind),
    .width        (width),
    .height       (height),
    .channels     (channels),
    .image_kind   (image_kind),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha),
    .repeat_res   (repeat_res),
    .last         (last)
  );

  always #5 clk = ~clk;

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words still awaited", $time, awaited_words.size());
      $display("tb_tga_rle_stream_decoder NOT OK");
      $finish;
    end
  end

  task automatic decoder_clear();
    dec_phase    = PH_HEADER;
    dec_hdr_idx  = '0;
    dec_type     = '0;
    dec_w        = '0;
    dec_h        = '0;
    dec_bpp      = '0;
    dec_px_left  = '0;
    dec_pkt_left = '0;
    dec_run      = 1'b0;
    dec_pix_byte = '0;
    dec_bgr      = '0;
  endtask

  // Advance the decoder model by one file byte; hit says whether a word comes out.
  task automatic tga_decode_byte(input logic [7:0] b, input logic sof, output logic hit,
                                 output trle_result_t res);
    logic        depth_ok;
    logic [1:0]  ik;
    logic [1:0]  top_byte;
    logic [7:0]  alpha_b;
    logic [31:0] rep;
    hit = 1'b0;
    res = '0;
    alpha_b = 8'd0;
    if (sof) decoder_clear();
    case (dec_phase)
      PH_HEADER: begin
        case (dec_hdr_idx)
          HDR_TYPE:      dec_type = b;
          HDR_WIDTH_LO:  dec_w[7:0] = b;
          HDR_WIDTH_HI:  dec_w[15:8] = b;
          HDR_HEIGHT_LO: dec_h[7:0] = b;
          HDR_HEIGHT_HI: dec_h[15:8] = b;
          HDR_DEPTH:     dec_bpp = b;
          default: ;
        endcase
        // The last header byte settles the image kind and the pixel budget.
        if (dec_hdr_idx == HDR_LAST) begin
          depth_ok = (dec_bpp == DEPTH_24) || (dec_bpp == DEPTH_32);
          if (depth_ok && dec_type == TYPE_TRUECOLOR) ik = IMG_RAW;
          else if (depth_ok && dec_type == TYPE_RLE_TRUECOLOR) ik = IMG_RLE;
          else ik = IMG_UNSUP;
          dec_px_left  = {16'd0, dec_w} * {16'd0, dec_h};
          dec_pix_byte = '0;
          dec_pkt_left = '0;
          dec_run      = 1'b0;
          dec_bgr      = '0;
          res.kind       = KIND_HEADER;
          res.width      = dec_w;
          res.height     = dec_h;
          res.channels   = (dec_bpp > DEPTH_24) ? CH_RGBA : CH_RGB;
          res.image_kind = ik;
          hit = 1'b1;
          if (ik == IMG_UNSUP || dec_px_left == 0) begin
            res.last  = 1'b1;
            dec_phase = PH_DONE;
          end else if (ik == IMG_RAW) begin
            dec_phase = PH_RAWIMG;
          end else begin
            dec_phase = PH_PKTHDR;
          end
        end
        dec_hdr_idx = dec_hdr_idx + 5'd1;
      end
      PH_PKTHDR: begin
        if (b <= PKT_RUN_BASE) begin
          dec_pkt_left = b + 8'd1;
          dec_run      = 1'b0;
        end else begin
          dec_pkt_left = b - PKT_RUN_BASE;
          dec_run      = 1'b1;
        end
        dec_pix_byte = '0;
        dec_phase    = PH_PKTPIX;
      end
      PH_RAWIMG, PH_PKTPIX: begin
        top_byte = (dec_bpp == DEPTH_32) ? 2'd3 : 2'd2;
        if (dec_pix_byte == 2'd3) alpha_b = b;
        else dec_bgr[8*dec_pix_byte +: 8] = b;
        if (dec_pix_byte < top_byte) begin
          dec_pix_byte = dec_pix_byte + 2'd1;
        end else begin
          // A whole pixel is in: runs repeat it, clipped to what the image still needs.
          dec_pix_byte = '0;
          rep = 32'd1;
          if (dec_phase == PH_PKTPIX && dec_run) begin
            rep = {24'd0, dec_pkt_left};
            dec_pkt_left = '0;
          end
          if (rep > dec_px_left) rep = dec_px_left;
          dec_px_left = dec_px_left - rep;
          if (dec_phase == PH_PKTPIX && !dec_run) dec_pkt_left = dec_pkt_left - 8'd1;
          res.kind       = KIND_PIXEL;
          res.red        = dec_bgr[23:16];
          res.green      = dec_bgr[15:8];
          res.blue       = dec_bgr[7:0];
          res.alpha      = alpha_b;
          res.repeat_res = rep[7:0];
          res.last       = (dec_px_left == 0);
          hit = 1'b1;
          if (res.last) dec_phase = PH_DONE;
          else if (dec_phase == PH_PKTPIX && (dec_run || dec_pkt_left == 0)) dec_phase = PH_PKTHDR;
        end
      end
      default: ;
    endcase
  endtask

  // Present one byte, wait for the handshake and queue the word it should produce.
  task automatic send_byte(input logic [7:0] b, input logic sof, input logic pinned,
                           input trle_result_t pin_word);
    int           gap;
    logic         hit;
    trle_result_t res;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 7);
      byte_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_valid    <= 1'b1;
    data_byte     <= b;
    start_of_file <= sof;
    do @(posedge clk); while (!byte_ready);
    if (sof || dec_phase != PH_DONE) live_bytes++;
    tga_decode_byte(b, sof, hit, res);
    if (pinned) awaited_words.push_back(pin_word);
    else if (hit) awaited_words.push_back(res);
    @(negedge clk);
  endtask

  // Stop sending until every awaited word has come back.
  task automatic hold_until_drained();
    byte_valid <= 1'b0;
    do @(negedge clk); while (awaited_words.size() != 0);
  endtask

  function automatic logic [7:0] header_byte(input logic [4:0] idx, input logic [7:0] typ,
                                             input logic [15:0] w, input logic [15:0] h,
                                             input logic [7:0] bpp);
    case (idx)
      HDR_TYPE:      return typ;
      HDR_WIDTH_LO:  return w[7:0];
      HDR_WIDTH_HI:  return w[15:8];
      HDR_HEIGHT_LO: return h[7:0];
      HDR_HEIGHT_HI: return h[15:8];
      HDR_DEPTH:     return bpp;
      default:       return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Send the first len header bytes; fields the decoder skips are random.
  task automatic send_header(input logic sof, input logic [4:0] len, input logic [7:0] typ,
                             input logic [15:0] w, input logic [15:0] h, input logic [7:0] bpp,
                             input logic pinned, input trle_result_t pin_word);
    logic [4:0] idx;
    for (idx = 0; idx < len; idx++)
      send_byte(header_byte(idx, typ, w, h, bpp), sof && idx == 0,
                pinned && idx == HDR_LAST, pin_word);
  endtask

  task automatic send_pixel(input int nch);
    repeat (nch) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
  endtask

  // A full header followed by pixel data, stopping at the image end or after px_budget stored pixels.
  task automatic send_image(input logic sof, input logic [7:0] typ, input logic [15:0] w,
                            input logic [15:0] h, input logic [7:0] bpp, input int px_budget);
    longint remaining;
    int     budget;
    int     cnt;
    int     k;
    int     nch;
    send_header(sof, HDR_FULL, typ, w, h, bpp, 1'b0, '0);
    remaining = longint'(w);
    remaining = remaining * h;
    nch = (bpp == DEPTH_32) ? 4 : 3;
    budget = px_budget;
    while (remaining > 0 && budget > 0) begin
      if (typ == TYPE_RLE_TRUECOLOR) begin
        cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 4);
        if ($urandom_range(0, 1) == 1) begin
          // Run packet; a long run may overshoot the end of the image.
          send_byte(8'(PKT_RUN_BASE + cnt), 1'b0, 1'b0, '0);
          send_pixel(nch);
          remaining = remaining - ((cnt < remaining) ? cnt : remaining);
          budget--;
        end else begin
          send_byte(8'(cnt - 1), 1'b0, 1'b0, '0);
          k = cnt;
          if (k > remaining) k = int'(remaining);
          if (k > budget) k = budget;
          repeat (k) send_pixel(nch);
          remaining = remaining - k;
          budget = budget - k;
        end
      end else begin
        send_pixel(nch);
        remaining--;
        budget--;
      end
    end
  endtask

  function automatic file_row_t dir_file(input logic sof, input logic [4:0] hdr_len,
      input logic [7:0] typ, input logic [15:0] w, input logic [15:0] h, input logic [7:0] bpp,
      input logic [4:0] body_len, input logic [127:0] body, input logic pinned,
      input logic [2:0] ch, input logic [1:0] ik, input logic fin);
    file_row_t r;
    r = '0;
    r.sof      = sof;
    r.hdr_len  = hdr_len;
    r.img_type = typ;
    r.w        = w;
    r.h        = h;
    r.bpp      = bpp;
    r.body_len = body_len;
    r.body     = body;
    r.pinned   = pinned;
    r.hdr_word.kind       = KIND_HEADER;
    r.hdr_word.width      = w;
    r.hdr_word.height     = h;
    r.hdr_word.channels   = ch;
    r.hdr_word.image_kind = ik;
    r.hdr_word.last       = fin;
    return r;
  endfunction

  // Receiver: ready with random stall bursts while idling is on.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      result_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left   <= $urandom_range(0, 6);
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  task automatic cmp_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors = errors + 1;
    end
  endtask

  // Compare each accepted word with the oldest one awaited.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (awaited_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual kind %0d last %0d",
                 $time, kind, last);
        errors = errors + 1;
      end else begin
        oldest_word = awaited_words.pop_front();
        cmp_field("kind", 16'(oldest_word.kind), 16'(kind));
        cmp_field("width", oldest_word.width, width);
        cmp_field("height", oldest_word.height, height);
        cmp_field("channels", 16'(oldest_word.channels), 16'(channels));
        cmp_field("image_kind", 16'(oldest_word.image_kind), 16'(image_kind));
        cmp_field("red", 16'(oldest_word.red), 16'(red));
        cmp_field("green", 16'(oldest_word.green), 16'(green));
        cmp_field("blue", 16'(oldest_word.blue), 16'(blue));
        cmp_field("alpha", 16'(oldest_word.alpha), 16'(alpha));
        cmp_field("repeat_res", 16'(oldest_word.repeat_res), 16'(repeat_res));
        cmp_field("last", 16'(oldest_word.last), 16'(last));
        if (oldest_word.kind == KIND_HEADER) header_words++;
        else pixel_words++;
        if (oldest_word.kind == KIND_PIXEL && oldest_word.repeat_res > 8'd1) run_words++;
      end
    end
  end

  initial begin
    file_row_t   row;
    int          pick;
    logic        sof;
    logic [7:0]  typ;
    logic [7:0]  bpp;
    logic [15:0] w;
    logic [15:0] h;

    // Directed files. Body bytes are listed in stream order.
    // First file has no start mark right after reset; 1x1 raw with extreme bytes.
    dir_files[0]  = dir_file(1'b0, HDR_FULL, TYPE_TRUECOLOR, 16'd1, 16'd1, DEPTH_24,
                             5'd3, 128'h00FF80, 1'b1, CH_RGB, IMG_RAW, 1'b0);
    // Raw 32-bit pixels, all zeros then all ones.
    dir_files[1]  = dir_file(1'b1, HDR_FULL, TYPE_TRUECOLOR, 16'd2, 16'd1, DEPTH_32,
                             5'd8, 128'h00000000_FFFFFFFF, 1'b1, CH_RGBA, IMG_RAW, 1'b0);
    // RLE: run of two, raw of one, longest run cut at the image end, then ignored bytes.
    dir_files[2]  = dir_file(1'b1, HDR_FULL, TYPE_RLE_TRUECOLOR, 16'd3, 16'd2, DEPTH_24,
                             5'd14, 128'h81102030_00405060_FF708090_55AA, 1'b1,
                             CH_RGB, IMG_RLE, 1'b0);
    // Largest image; longest raw packet, abandoned after two pixels.
    dir_files[3]  = dir_file(1'b1, HDR_FULL, TYPE_RLE_TRUECOLOR, 16'hFFFF, 16'hFFFF, DEPTH_32,
                             5'd9, 128'h7F_01020304_FBFCFDFE, 1'b1, CH_RGBA, IMG_RLE, 1'b0);
    // Header cut short by the next start mark.
    dir_files[4]  = dir_file(1'b1, 5'd9, TYPE_RLE_TRUECOLOR, 16'd1, 16'd1, DEPTH_24,
                             5'd0, 128'h0, 1'b0, CH_RGB, IMG_RLE, 1'b0);
    // Unsupported types and depths; the bytes after them are ignored.
    dir_files[5]  = dir_file(1'b1, HDR_FULL, TYPE_GRAY, 16'd5, 16'd5, DEPTH_24,
                             5'd2, 128'hFF00, 1'b1, CH_RGB, IMG_UNSUP, 1'b1);
    dir_files[6]  = dir_file(1'b1, HDR_FULL, TYPE_TRUECOLOR, 16'd4, 16'd4, DEPTH_16,
                             5'd0, 128'h0, 1'b1, CH_RGB, IMG_UNSUP, 1'b1);
    dir_files[7]  = dir_file(1'b1, HDR_FULL, TYPE_RLE_TRUECOLOR, 16'd1, 16'd1, DEPTH_MAX,
                             5'd0, 128'h0, 1'b1, CH_RGBA, IMG_UNSUP, 1'b1);
    dir_files[8]  = dir_file(1'b1, HDR_FULL, TYPE_BOGUS, 16'd7, 16'd3, DEPTH_32,
                             5'd0, 128'h0, 1'b1, CH_RGBA, IMG_UNSUP, 1'b1);
    // Empty images end with the header word.
    dir_files[9]  = dir_file(1'b1, HDR_FULL, TYPE_TRUECOLOR, 16'd0, 16'd9, DEPTH_24,
                             5'd3, 128'hABCDEF, 1'b1, CH_RGB, IMG_RAW, 1'b1);
    dir_files[10] = dir_file(1'b1, HDR_FULL, TYPE_RLE_TRUECOLOR, 16'd4, 16'd0, DEPTH_32,
                             5'd0, 128'h0, 1'b1, CH_RGBA, IMG_RLE, 1'b1);
    // Raw packet that ends exactly with the image.
    dir_files[11] = dir_file(1'b1, HDR_FULL, TYPE_RLE_TRUECOLOR, 16'd2, 16'd1, DEPTH_24,
                             5'd7, 128'h01_000000_FFFFFF, 1'b1, CH_RGB, IMG_RLE, 1'b0);
    dir_files[12] = dir_file(1'b1, HDR_FULL, TYPE_NONE, 16'd0, 16'd0, DEPTH_NONE,
                             5'd0, 128'h0, 1'b1, CH_RGB, IMG_UNSUP, 1'b1);

    decoder_clear();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int r = 0; r < $size(dir_files); r++) begin
      row = dir_files[r];
      send_header(row.sof, row.hdr_len, row.img_type, row.w, row.h, row.bpp,
                  row.pinned, row.hdr_word);
      for (int j = 0; j < row.body_len; j++)
        send_byte(row.body[8*(row.body_len-1-j) +: 8], 1'b0, 1'b0, '0);
      files_sent++;
    end
    hold_until_drained();

    // Random files: mostly small well-formed images, the rest broken or noise.
    while (live_bytes < ITEMS) begin
      if (live_bytes >= CALM_AFTER) idle_on = 1'b0;
      pick = $urandom_range(0, 99);
      sof  = ($urandom_range(0, 19) != 0);
      bpp  = ($urandom_range(0, 1) == 1) ? DEPTH_32 : DEPTH_24;
      typ  = ($urandom_range(0, 1) == 1) ? TYPE_RLE_TRUECOLOR : TYPE_TRUECOLOR;
      w    = 16'($urandom_range(1, 6));
      h    = 16'($urandom_range(1, 4));
      if (pick < 70) begin
        send_image(sof, typ, w, h, bpp, 1000);
      end else if (pick < 78) begin
        // Huge image, abandoned after a few pixels.
        send_image(sof, typ, 16'($urandom_range(256, 65535)), 16'($urandom_range(0, 65535)),
                   bpp, $urandom_range(1, 6));
      end else if (pick < 86) begin
        send_image(sof, 8'($urandom_range(0, 255)), w, h, 8'($urandom_range(0, 255)), 3);
      end else if (pick < 90) begin
        if ($urandom_range(0, 1) == 1) w = 16'd0;
        else h = 16'd0;
        send_image(sof, typ, w, h, bpp, 2);
      end else if (pick < 95) begin
        send_header(1'b1, 5'($urandom_range(1, 17)), typ, w, h, bpp, 1'b0, '0);
      end else begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
      end
      // Trailing bytes past the end of an image.
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
      if ($urandom_range(0, 39) == 0) hold_until_drained();
      files_sent++;
    end

    idle_on = 1'b0;
    byte_valid <= 1'b0;
    while (awaited_words.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Streamed %0d files, %0d bytes that reached the decoder.", files_sent, live_bytes);
    $display("Checked %0d header words and %0d pixel words, %0d of them runs.",
             header_words, pixel_words, run_words);
    if (errors == 0) begin
      $display("tb_tga_rle_stream_decoder OK");
    end else begin
      $display("tb_tga_rle_stream_decoder NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/trle_pkg.sv
rtl/core/trle_out_reg.sv
rtl/core/tga_rle_stream_decoder.sv
rtl/core/trle_chk.sv
verif/tb_tga_rle_stream_decoder.sv
